@@ rtl/core/crn_pkg.sv @@
// shared constants, types and saturation helpers for the cubic root finder
package crn_pkg;

   localparam int FRAC_BITS      = 16;
   localparam int MAX_ITERATIONS = 64;
   localparam int DATA_W         = 32;
   localparam int CNT_W          = 7;
   localparam int ERR_W          = 31;
   localparam int CSR_IDX_W      = 3;
   localparam int DIV_W          = 64;

   localparam logic signed [DATA_W-1:0] COEF_CUBIC_RST  = 32'sd131072;
   localparam logic signed [DATA_W-1:0] COEF_SQUARE_RST = -32'sd720896;
   localparam logic signed [DATA_W-1:0] COEF_LINEAR_RST = 32'sd1159987;
   localparam logic signed [DATA_W-1:0] COEF_CONST_RST  = -32'sd327680;

   localparam logic [ERR_W-1:0] ERR_MAX = {ERR_W{1'b1}};

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_COEF_CUBIC  = 3'd0,
      REG_COEF_SQUARE = 3'd1,
      REG_COEF_LINEAR = 3'd2,
      REG_COEF_CONST  = 3'd3,
      REG_METHOD_MODE = 3'd4
   } reg_index_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_DEN_ZERO = 2'd1,
      STATUS_EST_ZERO = 2'd2
   } status_type;

   localparam logic MODE_NEWTON = 1'b0;
   localparam logic MODE_SECANT = 1'b1;

   // clamp a wide signed value into the 32-bit signed range
   function automatic logic signed [DATA_W-1:0] sat_wide(input logic signed [63:0] v);
      logic signed [DATA_W-1:0] r;
      if (v > 64'sh0000_0000_7FFF_FFFF) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -64'sh0000_0000_8000_0000) begin
         r = -32'sh8000_0000;
      end else begin
         r = v[DATA_W-1:0];
      end
      return r;
   endfunction

   // apply the sign to an unsigned quotient magnitude and clamp
   function automatic logic signed [DATA_W-1:0] sat_quot(input logic [DIV_W-1:0] q,
                                                        input logic neg);
      logic [DIV_W-1:0]         nq;
      logic signed [DATA_W-1:0] r;
      nq = ~q + 64'd1;
      if (neg) begin
         if (q > 64'h0000_0000_8000_0000) begin
            r = -32'sh8000_0000;
         end else begin
            r = nq[DATA_W-1:0];
         end
      end else begin
         if (q > 64'h0000_0000_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
         end else begin
            r = q[DATA_W-1:0];
         end
      end
      return r;
   endfunction

endpackage

@@ rtl/core/crn_if.sv @@
// request and response channel interfaces of the cubic root finder
interface crn_req_if import crn_pkg::*;;
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] start_first;
   logic signed [DATA_W-1:0] start_second;
   logic [CNT_W-1:0]         iteration_count;

   modport source(output valid, output start_first, output start_second,
                  output iteration_count, input ready);
   modport sink(input valid, input start_first, input start_second,
                input iteration_count, output ready);
endinterface

interface crn_rsp_if import crn_pkg::*;;
   logic                     valid;
   logic                     ready;
   logic [CNT_W-1:0]         step_index;
   logic signed [DATA_W-1:0] estimate;
   logic [ERR_W-1:0]         relative_error_pct;
   logic [1:0]               status;
   logic                     last_result;

   modport source(output valid, output step_index, output estimate,
                  output relative_error_pct, output status, output last_result,
                  input ready);
   modport sink(input valid, input step_index, input estimate,
                input relative_error_pct, input status, input last_result,
                output ready);
endinterface

@@ rtl/core/crn_mul.sv @@
// shared fixed-point multiplier: floor shift and saturation, registered result
module crn_mul import crn_pkg::*; (
   input  logic                     clock,
   input  logic signed [DATA_W-1:0] op_a,
   input  logic signed [DATA_W-1:0] op_b,
   output logic signed [DATA_W-1:0] prod_q
);

   logic signed [63:0]       prod;
   logic signed [63:0]       prod_sh;
   logic signed [DATA_W-1:0] prod_q_ff;
   logic signed [DATA_W-1:0] prod_q_in;

   always_comb begin
      prod      = 64'(op_a) * 64'(op_b);
      // arithmetic shift rounds toward minus infinity
      prod_sh   = prod >>> FRAC_BITS;
      prod_q_in = sat_wide(prod_sh);
   end

   always_ff @(posedge clock) begin
      prod_q_ff <= prod_q_in;
   end

   assign prod_q = prod_q_ff;

endmodule

@@ rtl/core/crn_div.sv @@
// radix-2 restoring divider, one quotient bit per cycle
module crn_div import crn_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIV_W-1:0]  dividend,
   input  logic [DATA_W-1:0] divisor,
   output logic              busy,
   output logic              done,
   output logic [DIV_W-1:0]  quotient
);

   localparam int CYC_W = $clog2(DIV_W + 1);

   logic [CYC_W-1:0]  cnt_ff, cnt_in;
   logic              done_ff, done_in;
   logic [DIV_W-1:0]  quo_ff, quo_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DATA_W-1:0] dvs_ff, dvs_in;
   logic [DATA_W:0]   shifted;
   logic [DATA_W:0]   diff;
   logic              fits;

   assign busy = (cnt_ff != '0);

   always_comb begin
      shifted = {rem_ff, quo_ff[DIV_W-1]};
      diff    = shifted - {1'b0, dvs_ff};
      fits    = (shifted >= {1'b0, dvs_ff});
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
         cnt_in = CYC_W'(DIV_W);
      end else if (busy) begin
         quo_in = {quo_ff[DIV_W-2:0], fits};
         rem_in = fits ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CYC_W'(1)) begin
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

@@ rtl/core/cubic_root_newton_secant_top.sv @@
// top level of the cubic root finder: sequencer, registers and output stage
//
// Finds a root of f(x) = c3*x^3 + c2*x^2 + c1*x + c0 in signed Q16.16.
// csr port: write enable, index (0..3 coefficients, 4 method, 0 Newton 1 secant)
// and 32-bit data; write only while no run is in progress.
// req channel: start_first, start_second (secant only) and iteration_count.
// One request starts a run of up to 64 iterations; a count of zero gives
// nothing, counts above 64 are clipped. Each iteration gives one rsp transfer
// with step_index, estimate, relative_error_pct, status and last_result.
// A zero denominator gives a final result with status 1 and ends the run.
// Each iteration has polynomial work on the one shared multiplier
// (secant mode evaluates f at both estimates), a check step, two
// passes of the shared bit-serial divider (step and relative change)
// with an update step between them, and a step to hand the result
// over. A zero estimate skips the second pass.
// req ready is high only between runs. Results sit in an output register;
// the sequencer keeps working on the next iteration while one is waiting and
// stalls only when a second result is ready before the first is taken.
// Reset is synchronous: coefficients return to 2, -11, 17.7, -5, Newton mode.
module cubic_root_newton_secant_top import crn_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   crn_req_if.sink              req_ch,
   crn_rsp_if.source            rsp_ch,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]    csr_data
);

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b000_0001,
      ST_EVAL  = 7'b000_0010,
      ST_CHECK = 7'b000_0100,
      ST_DSTEP = 7'b000_1000,
      ST_UPD   = 7'b001_0000,
      ST_DREL  = 7'b010_0000,
      ST_EMIT  = 7'b100_0000
   } state_type;

   state_type state_ff, state_in;

   logic signed [DATA_W-1:0] c3_ff, c3_in, c2_ff, c2_in, c1_ff, c1_in, c0_ff, c0_in;
   logic                     mode_ff, mode_in;

   logic signed [DATA_W-1:0] x_ff, x_in, prev_ff, prev_in, nx_ff, nx_in;
   logic signed [DATA_W-1:0] x2_ff, x2_in, fx_ff, fx_in, num_ff, num_in, den_ff, den_in;
   logic signed [34:0]       acc_ff, acc_in;
   logic [2:0]               uop_ff, uop_in;
   logic                     pass_ff, pass_in;
   logic                     neg_ff, neg_in;
   logic [CNT_W-1:0]         iter_ff, iter_in, n_ff, n_in;

   logic signed [DATA_W-1:0] res_est_ff, res_est_in;
   logic [ERR_W-1:0]         res_err_ff, res_err_in;
   status_type               res_st_ff, res_st_in;
   logic                     res_last_ff, res_last_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]         out_idx_ff, out_idx_in;
   logic signed [DATA_W-1:0] out_est_ff, out_est_in;
   logic [ERR_W-1:0]         out_err_ff, out_err_in;
   status_type               out_st_ff, out_st_in;
   logic                     out_last_ff, out_last_in;

   logic signed [DATA_W-1:0] mul_a, mul_b, mul_q, p_op, diff_px, f_sum;
   logic signed [DATA_W-1:0] step_q, nx_new;
   logic                     div_start, div_busy, div_done;
   logic [DIV_W-1:0]         div_dividend, div_quotient;
   logic [DATA_W-1:0]        div_divisor;
   logic [DATA_W-1:0]        abs_num, abs_den, abs_nx;
   logic signed [DATA_W:0]   d_nx;
   logic [DATA_W:0]          abs_d;
   logic [39:0]              ad100;
   logic                     req_xfer, rsp_xfer, load_out;
   logic [CNT_W-1:0]         n_req;

   crn_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod_q(mul_q)
   );

   crn_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(div_dividend),
      .divisor (div_divisor),
      .busy    (div_busy),
      .done    (div_done),
      .quotient(div_quotient)
   );

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_xfer     = req_ch.valid && req_ch.ready;
   assign rsp_xfer     = rsp_valid_ff && rsp_ch.ready;

   always_comb begin
      p_op    = pass_ff ? prev_ff : x_ff;
      diff_px = sat_wide(64'(prev_ff) - 64'(x_ff));
      f_sum   = sat_wide(64'(acc_ff) + 64'(mul_q) + 64'(c0_ff));
      step_q  = sat_quot(div_quotient, neg_ff);
      nx_new  = sat_wide(64'(x_ff) - 64'(step_q));
      abs_num = num_ff[DATA_W-1] ? (~num_ff + 32'd1) : num_ff;
      abs_den = den_ff[DATA_W-1] ? (~den_ff + 32'd1) : den_ff;
      abs_nx  = nx_ff[DATA_W-1] ? (~nx_ff + 32'd1) : nx_ff;
      d_nx    = 33'(nx_ff) - 33'(x_ff);
      abs_d   = d_nx[DATA_W] ? (~d_nx + 33'd1) : d_nx;
      ad100   = 40'(abs_d) * 40'd100;
      n_req   = (req_ch.iteration_count > CNT_W'(MAX_ITERATIONS)) ?
                CNT_W'(MAX_ITERATIONS) : req_ch.iteration_count;
   end

   // operand selection for the shared multiplier, one product per micro step
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (uop_ff)
         3'd0: begin mul_a = p_op;  mul_b = p_op;  end
         3'd1: begin mul_a = mul_q; mul_b = p_op;  end
         3'd2: begin mul_a = c3_ff; mul_b = mul_q; end
         3'd3: begin mul_a = c2_ff; mul_b = x2_ff; end
         3'd4: begin mul_a = c1_ff; mul_b = p_op;  end
         3'd5: begin
            if (mode_ff == MODE_SECANT) begin
               mul_a = fx_ff; mul_b = diff_px;
            end else begin
               mul_a = c3_ff; mul_b = x2_ff;
            end
         end
         3'd6: begin mul_a = c2_ff; mul_b = x_ff; end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   always_comb begin
      c3_in = c3_ff; c2_in = c2_ff; c1_in = c1_ff; c0_in = c0_ff; mode_in = mode_ff;
      if (csr_wr_en) begin
         case (csr_index)
            REG_COEF_CUBIC:  c3_in   = csr_data;
            REG_COEF_SQUARE: c2_in   = csr_data;
            REG_COEF_LINEAR: c1_in   = csr_data;
            REG_COEF_CONST:  c0_in   = csr_data;
            REG_METHOD_MODE: mode_in = csr_data[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      x_in         = x_ff;
      prev_in      = prev_ff;
      nx_in        = nx_ff;
      x2_in        = x2_ff;
      fx_in        = fx_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      acc_in       = acc_ff;
      uop_in       = uop_ff;
      pass_in      = pass_ff;
      neg_in       = neg_ff;
      iter_in      = iter_ff;
      n_in         = n_ff;
      res_est_in   = res_est_ff;
      res_err_in   = res_err_ff;
      res_st_in    = res_st_ff;
      res_last_in  = res_last_ff;
      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = '0;
      load_out     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer && n_req != '0) begin
               prev_in  = req_ch.start_first;
               x_in     = (mode_ff == MODE_SECANT) ? req_ch.start_second
                                                   : req_ch.start_first;
               n_in     = n_req;
               iter_in  = CNT_W'(1);
               uop_in   = '0;
               pass_in  = 1'b0;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            uop_in = uop_ff + 3'd1;
            case (uop_ff)
               3'd1: x2_in = mul_q;
               3'd3: acc_in = 35'(mul_q);
               3'd4: acc_in = acc_ff + 35'(mul_q);
               3'd5: begin
                  if (mode_ff == MODE_NEWTON) begin
                     num_in = f_sum;
                  end else if (!pass_ff) begin
                     // f at the current estimate done, now f at the older one
                     fx_in   = f_sum;
                     pass_in = 1'b1;
                     uop_in  = '0;
                  end else begin
                     den_in = sat_wide(64'(f_sum) - 64'(fx_ff));
                  end
               end
               3'd6: begin
                  if (mode_ff == MODE_SECANT) begin
                     num_in   = mul_q;
                     state_in = ST_CHECK;
                  end else begin
                     acc_in = 35'(mul_q) * 35'sd3;
                  end
               end
               3'd7: begin
                  den_in   = sat_wide(64'(acc_ff) + 64'(mul_q) * 64'sd2 + 64'(c1_ff));
                  state_in = ST_CHECK;
               end
               default: ;
            endcase
         end
         ST_CHECK: begin
            if (den_ff == '0) begin
               res_est_in  = x_ff;
               res_err_in  = '0;
               res_st_in   = STATUS_DEN_ZERO;
               res_last_in = 1'b1;
               state_in    = ST_EMIT;
            end else begin
               div_start    = 1'b1;
               div_dividend = DIV_W'(abs_num) << FRAC_BITS;
               div_divisor  = abs_den;
               neg_in       = num_ff[DATA_W-1] ^ den_ff[DATA_W-1];
               state_in     = ST_DSTEP;
            end
         end
         ST_DSTEP: begin
            if (div_done) begin
               nx_in    = nx_new;
               state_in = ST_UPD;
            end
         end
         ST_UPD: begin
            res_last_in = (iter_ff == n_ff);
            if (nx_ff == '0) begin
               res_est_in = '0;
               res_err_in = ERR_MAX;
               res_st_in  = STATUS_EST_ZERO;
               state_in   = ST_EMIT;
            end else begin
               div_start    = 1'b1;
               div_dividend = DIV_W'(ad100) << FRAC_BITS;
               div_divisor  = abs_nx;
               state_in     = ST_DREL;
            end
         end
         ST_DREL: begin
            if (div_done) begin
               res_est_in = nx_ff;
               res_err_in = (div_quotient > DIV_W'(ERR_MAX)) ? ERR_MAX
                                                             : div_quotient[ERR_W-1:0];
               res_st_in  = STATUS_OK;
               state_in   = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               load_out = 1'b1;
               if (res_last_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  prev_in  = x_ff;
                  x_in     = nx_ff;
                  iter_in  = iter_ff + CNT_W'(1);
                  uop_in   = '0;
                  pass_in  = 1'b0;
                  state_in = ST_EVAL;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // output register decouples the sequencer from a stalling receiver
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      out_idx_in   = out_idx_ff;
      out_est_in   = out_est_ff;
      out_err_in   = out_err_ff;
      out_st_in    = out_st_ff;
      out_last_in  = out_last_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
         out_idx_in   = iter_ff;
         out_est_in   = res_est_ff;
         out_err_in   = res_err_ff;
         out_st_in    = res_st_ff;
         out_last_in  = res_last_ff;
      end else if (rsp_xfer) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         c3_ff        <= COEF_CUBIC_RST;
         c2_ff        <= COEF_SQUARE_RST;
         c1_ff        <= COEF_LINEAR_RST;
         c0_ff        <= COEF_CONST_RST;
         mode_ff      <= MODE_NEWTON;
         uop_ff       <= '0;
         pass_ff      <= 1'b0;
         iter_ff      <= '0;
         n_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         c3_ff        <= c3_in;
         c2_ff        <= c2_in;
         c1_ff        <= c1_in;
         c0_ff        <= c0_in;
         mode_ff      <= mode_in;
         uop_ff       <= uop_in;
         pass_ff      <= pass_in;
         iter_ff      <= iter_in;
         n_ff         <= n_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      prev_ff     <= prev_in;
      nx_ff       <= nx_in;
      x2_ff       <= x2_in;
      fx_ff       <= fx_in;
      num_ff      <= num_in;
      den_ff      <= den_in;
      acc_ff      <= acc_in;
      neg_ff      <= neg_in;
      res_est_ff  <= res_est_in;
      res_err_ff  <= res_err_in;
      res_st_ff   <= res_st_in;
      res_last_ff <= res_last_in;
      out_idx_ff  <= out_idx_in;
      out_est_ff  <= out_est_in;
      out_err_ff  <= out_err_in;
      out_st_ff   <= out_st_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_ch.valid              = rsp_valid_ff;
   assign rsp_ch.step_index         = out_idx_ff;
   assign rsp_ch.estimate           = out_est_ff;
   assign rsp_ch.relative_error_pct = out_err_ff;
   assign rsp_ch.status             = out_st_ff;
   assign rsp_ch.last_result        = out_last_ff;

   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy)
      else $error("divider started while busy");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      load_out |-> (!rsp_valid_ff || rsp_ch.ready))
      else $error("output register overwritten before transfer");

   a_iter_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (iter_ff >= CNT_W'(1) && iter_ff <= n_ff))
      else $error("iteration index out of run range");

   a_div_done_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DSTEP || state_ff == ST_DREL))
      else $error("quotient ready outside a divide wait");

endmodule
